// ===== design/image_rotate_flip_remap_macros.svh =====
// Assertion macros shared by the image orientation remapper.
`ifndef IMAGE_ROTATE_FLIP_REMAP_MACROS_SVH
`define IMAGE_ROTATE_FLIP_REMAP_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define IRFR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a condition in the cycle after its trigger.
`define IRFR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/irfr_pkg.sv =====
// Shared types, constants and helper functions of the image orientation remapper.
package irfr_pkg;

	localparam int MAX_DIM    = 256;
	localparam int PIXEL_BITS = 32;

	localparam int IDX_W   = 8;
	localparam int DIM_W   = 9;
	localparam int PIX_W   = 32;
	localparam int ANG_W   = 16;
	localparam int CMD_W   = 3;
	localparam int DATA_W  = 32;
	localparam int PADDR_W = 3;
	localparam int REG_SEL_BIT = 2;

	localparam int CRD_W   = $clog2(MAX_DIM);
	localparam int EXT_W   = (CRD_W > DIM_W) ? CRD_W : DIM_W;
	localparam int ADDR_W  = 2 * CRD_W;
	localparam int RAM_DEPTH = 1 << ADDR_W;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = FIFO_AW + 1;

	// floor(x / 90) for x below 2^16 as (x * RECIP_90) >> RECIP_SHIFT, exact
	localparam int DEG_QUARTER = 90;
	localparam logic [ANG_W-1:0] RECIP_90 = 16'd46604;
	localparam int RECIP_SHIFT = 22;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD    = 3'd0,
		CMD_ROT_CW  = 3'd1,
		CMD_ROT_CCW = 3'd2,
		CMD_MIR_LR  = 3'd3,
		CMD_MIR_UD  = 3'd4,
		CMD_READ    = 3'd5
	} cmd_t;

	typedef enum logic {
		REG_NUM_ROWS = 1'b0,
		REG_NUM_COLS = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic                  is_read;
		logic                  ok;
		logic [ADDR_W-1:0]     addr;
		logic [PIXEL_BITS-1:0] data;
		logic [DIM_W-1:0]      height;
		logic [DIM_W-1:0]      width;
	} irfr_op_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (32'(v) > MAX_DIM) begin
			r = DIM_W'(MAX_DIM);
		end else begin
			r = v;
		end
		return r;
	endfunction

	// Quarter turns of an angle, modulo 4; negative angles round toward the next lower turn
	function automatic logic [1:0] turns_of(input logic signed [ANG_W:0] v);
		logic                 neg;
		logic [ANG_W:0]       mag;
		logic [ANG_W-1:0]     x;
		logic [2*ANG_W-1:0]   prod;
		logic [1:0]           q;
		neg  = v[ANG_W];
		mag  = neg ? unsigned'(-v) : unsigned'(v);
		x    = neg ? ANG_W'(32'(mag) + DEG_QUARTER - 1) : ANG_W'(mag);
		prod = (2*ANG_W)'(x) * (2*ANG_W)'(RECIP_90);
		q    = prod[RECIP_SHIFT+1:RECIP_SHIFT];
		return neg ? 2'(2'd0 - q) : q;
	endfunction

	function automatic logic [PIXEL_BITS-1:0] to_store(input logic [PIX_W-1:0] p);
		logic [PIXEL_BITS-1:0] s;
		for (int i = 0; i < PIXEL_BITS; i++) begin
			s[i] = (i < PIX_W) ? p[i % PIX_W] : 1'b0;
		end
		return s;
	endfunction

	function automatic logic [PIX_W-1:0] from_store(input logic [PIXEL_BITS-1:0] s);
		logic [PIX_W-1:0] p;
		for (int i = 0; i < PIX_W; i++) begin
			p[i] = (i < PIXEL_BITS) ? s[i % PIXEL_BITS] : 1'b0;
		end
		return p;
	endfunction

endpackage

// ===== design/irfr_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module irfr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// hold read data while no read is issued
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/irfr_front.sv =====
// Front end: takes commands, keeps the orientation state and maps reads and loads to addresses.
module irfr_front import irfr_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [CMD_W-1:0]        command,
	input  logic [IDX_W-1:0]        row_index,
	input  logic [IDX_W-1:0]        col_index,
	input  logic signed [PIX_W-1:0] pixel_in,
	input  logic signed [ANG_W-1:0] angle_degrees,
	input  logic [DIM_W-1:0]        num_rows,
	input  logic [DIM_W-1:0]        num_cols,
	input  fifo_stat_t              fifo_stat,
	output logic                    push,
	output irfr_op_t                push_op
);

	logic [1:0]              qt_q;
	logic                    mir_q;
	logic                    accept;
	logic                    push_req;
	logic [DIM_W-1:0]        h0, w0, ch, cw;
	logic [EXT_W-1:0]        row_e, col_e, h0m1, w0m1, r_map, c_map;
	logic                    ok;
	logic                    load_ok;
	logic signed [ANG_W:0]   ang_ext;
	logic signed [ANG_W:0]   ang_neg;

	assign in_stall = fifo_stat.full;
	assign accept   = in_valid && !fifo_stat.full;
	assign push     = accept && push_req;
	assign ang_ext  = (ANG_W+1)'(angle_degrees);
	assign ang_neg  = -ang_ext;

	always_comb begin
		h0    = clamp_dim(num_rows);
		w0    = clamp_dim(num_cols);
		ch    = qt_q[0] ? w0 : h0;
		cw    = qt_q[0] ? h0 : w0;
		row_e = EXT_W'(row_index);
		col_e = EXT_W'(col_index);
		h0m1  = EXT_W'(h0) - EXT_W'(1);
		w0m1  = EXT_W'(w0) - EXT_W'(1);
		// undo the clockwise turns, then the mirror
		case (qt_q)
			2'd0: begin
				r_map = row_e;
				c_map = col_e;
			end
			2'd1: begin
				r_map = h0m1 - col_e;
				c_map = row_e;
			end
			2'd2: begin
				r_map = h0m1 - row_e;
				c_map = w0m1 - col_e;
			end
			default: begin
				r_map = col_e;
				c_map = w0m1 - row_e;
			end
		endcase
		if (mir_q) begin
			c_map = w0m1 - c_map;
		end
		ok      = (DIM_W'(row_index) < ch) && (DIM_W'(col_index) < cw);
		load_ok = (32'(row_index) < MAX_DIM) && (32'(col_index) < MAX_DIM);

		push_op.is_read = 1'b0;
		push_op.ok      = ok;
		push_op.addr    = {row_e[CRD_W-1:0], col_e[CRD_W-1:0]};
		push_op.data    = to_store(pixel_in);
		push_op.height  = ch;
		push_op.width   = cw;
		push_req        = 1'b0;
		case (command)
			CMD_LOAD: begin
				push_req = load_ok;
			end
			CMD_READ: begin
				push_op.is_read = 1'b1;
				push_op.addr    = {r_map[CRD_W-1:0], c_map[CRD_W-1:0]};
				push_req        = 1'b1;
			end
			default: begin
				push_req = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qt_q  <= 2'd0;
			mir_q <= 1'b0;
		end else if (accept) begin
			case (command)
				CMD_ROT_CW: begin
					qt_q <= qt_q + turns_of(ang_ext);
				end
				CMD_ROT_CCW: begin
					qt_q <= qt_q + turns_of(ang_neg);
				end
				CMD_MIR_LR: begin
					qt_q  <= 2'd0 - qt_q;
					mir_q <= !mir_q;
				end
				CMD_MIR_UD: begin
					qt_q  <= 2'd2 - qt_q;
					mir_q <= !mir_q;
				end
				default: begin
					qt_q <= qt_q;
				end
			endcase
		end
	end

endmodule

// ===== design/irfr_fifo.sv =====
// Short queue of pending loads and reads between the front and back ends.
module irfr_fifo import irfr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  irfr_op_t   push_op,
	input  logic       pop,
	output irfr_op_t   pop_op,
	output fifo_stat_t stat
);

	irfr_op_t           mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_CW-1:0] count_q;

	assign stat.full  = (count_q == FIFO_CW'(FIFO_DEPTH));
	assign stat.empty = (count_q == '0);
	assign pop_op     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			case ({push, pop})
				2'b10: count_q <= count_q + FIFO_CW'(1);
				2'b01: count_q <= count_q - FIFO_CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== design/irfr_back.sv =====
// Back end: carries out queued loads and reads on the pixel store and holds the result beat.
module irfr_back import irfr_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  fifo_stat_t              fifo_stat,
	input  irfr_op_t                pop_op,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [PIX_W-1:0] pixel_out,
	output logic [DIM_W-1:0]        current_height,
	output logic [DIM_W-1:0]        current_width,
	output logic                    out_of_range
);

	logic                  out_valid_q;
	logic                  ok_q;
	logic [DIM_W-1:0]      height_q;
	logic [DIM_W-1:0]      width_q;
	logic                  pop_read;
	logic [PIXEL_BITS-1:0] rdata;

	// a read issues only when the result slot is free or is being taken
	assign pop      = !fifo_stat.empty && (!pop_op.is_read || !out_valid_q || !out_stall);
	assign pop_read = pop && pop_op.is_read;

	irfr_ram #(
		.WIDTH(PIXEL_BITS),
		.DEPTH(RAM_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (pop && !pop_op.is_read),
		.waddr(pop_op.addr),
		.wdata(pop_op.data),
		.re   (pop_read),
		.raddr(pop_op.addr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop_read) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_read) begin
			ok_q     <= pop_op.ok;
			height_q <= pop_op.height;
			width_q  <= pop_op.width;
		end
	end

	assign out_valid      = out_valid_q;
	assign pixel_out      = ok_q ? signed'(from_store(rdata)) : '0;
	assign current_height = height_q;
	assign current_width  = width_q;
	assign out_of_range   = !ok_q;

endmodule

// ===== design/image_rotate_flip_remap.sv =====
// Top level of the image orientation remapper: register port, front end, queue and back end.
//
// Holds a pixel matrix in its original orientation and a view onto it made of
// clockwise quarter turns and a left-right mirror bit. Rotate and mirror commands
// only change that view; loads write at original coordinates, reads give
// coordinates in the current view and return the pixel, the current height and
// width, and an out-of-range flag (with a zero pixel) for positions outside them.
// The front end takes one command per cycle and stalls only when its four-entry
// queue to the back end is full. The back end issues one load or read per cycle
// to the pixel store (one write port, one read port) while no read waits on a held
// result beat; a read's result beat is registered from the store once it leaves the queue.
// The pixel store needs no clearing after reset: a read of a position never
// loaded returns an unspecified value. Write num_rows and num_cols only while
// the block is idle; 0 acts as 1 and values above the maximum size are clamped.
`include "image_rotate_flip_remap_macros.svh"

module image_rotate_flip_remap import irfr_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [PADDR_W-1:0]      paddr,
	input  logic [DATA_W-1:0]       pwdata,
	output logic [DATA_W-1:0]       prdata,
	output logic                    pready,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [CMD_W-1:0]        command,
	input  logic [IDX_W-1:0]        row_index,
	input  logic [IDX_W-1:0]        col_index,
	input  logic signed [PIX_W-1:0] pixel_in,
	input  logic signed [ANG_W-1:0] angle_degrees,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [PIX_W-1:0] pixel_out,
	output logic [DIM_W-1:0]        current_height,
	output logic [DIM_W-1:0]        current_width,
	output logic                    out_of_range
);

	logic [DIM_W-1:0] num_rows_q;
	logic [DIM_W-1:0] num_cols_q;
	logic             cfg_write;
	reg_idx_t         reg_sel;
	logic             fifo_push;
	logic             fifo_pop;
	irfr_op_t         push_op;
	irfr_op_t         pop_op;
	fifo_stat_t       fifo_stat;
	logic             rd_accept;
	logic             dims_ok;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign reg_sel   = reg_idx_t'(paddr[REG_SEL_BIT]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= DIM_W'(1);
			num_cols_q <= DIM_W'(1);
		end else if (cfg_write) begin
			case (reg_sel)
				REG_NUM_ROWS: num_rows_q <= pwdata[DIM_W-1:0];
				REG_NUM_COLS: num_cols_q <= pwdata[DIM_W-1:0];
				default: num_rows_q <= num_rows_q;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_NUM_ROWS: prdata = DATA_W'(num_rows_q);
			REG_NUM_COLS: prdata = DATA_W'(num_cols_q);
			default: prdata = '0;
		endcase
	end

	irfr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.row_index    (row_index),
		.col_index    (col_index),
		.pixel_in     (pixel_in),
		.angle_degrees(angle_degrees),
		.num_rows     (num_rows_q),
		.num_cols     (num_cols_q),
		.fifo_stat    (fifo_stat),
		.push         (fifo_push),
		.push_op      (push_op)
	);

	irfr_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fifo_push),
		.push_op(push_op),
		.pop    (fifo_pop),
		.pop_op (pop_op),
		.stat   (fifo_stat)
	);

	irfr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.fifo_stat     (fifo_stat),
		.pop_op        (pop_op),
		.pop           (fifo_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.pixel_out     (pixel_out),
		.current_height(current_height),
		.current_width (current_width),
		.out_of_range  (out_of_range)
	);

	assign rd_accept = in_valid && !in_stall && (command == CMD_READ);
	assign dims_ok   = (current_height != '0) && (current_width != '0);

	`IRFR_ASSERT_NOW(a_no_push_full, fifo_push, !fifo_stat.full, "push into a full queue")
	`IRFR_ASSERT_NEXT(a_read_queued, rd_accept, !fifo_stat.empty, "accepted read was not queued")
	`IRFR_ASSERT_NOW(a_oor_zero, out_valid && out_of_range, pixel_out == '0, "out of range read returned data")
	`IRFR_ASSERT_NOW(a_dims_nonzero, out_valid, dims_ok, "zero dimension reported")

endmodule

// ===== test/image_rotate_flip_remap_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the image orientation remapper: directed rows, then random phases.
module image_rotate_flip_remap_tb;
	import irfr_pkg::*;

	localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;
	localparam int DRAIN_CYCLES     = 16;
	localparam int WATCHDOG_LIMIT   = 5000;
	localparam int RANDOM_PER_PHASE = 68;
	localparam int NUM_PHASES       = 9;
	localparam int MAX_PRINTS       = 100;

	typedef struct {
		logic [CMD_W-1:0]        cmd;
		logic [IDX_W-1:0]        row;
		logic [IDX_W-1:0]        col;
		logic signed [PIX_W-1:0] pix;
		logic signed [ANG_W-1:0] ang;
	} cmd_beat_t;

	typedef struct {
		logic [PIX_W-1:0] pix;
		logic [DIM_W-1:0] h;
		logic [DIM_W-1:0] w;
		logic             oor;
	} read_result_t;

	typedef struct {
		bit               is_cfg;
		logic [DIM_W-1:0] cfg_rows;
		logic [DIM_W-1:0] cfg_cols;
		cmd_beat_t        beat;
		bit               has_lit;
		read_result_t     lit;
	} stim_row_t;

	logic                    clk           = 1'b0;
	logic                    arst_n        = 1'b0;
	logic                    psel          = 1'b0;
	logic                    penable       = 1'b0;
	logic                    pwrite        = 1'b0;
	logic [PADDR_W-1:0]      paddr         = '0;
	logic [DATA_W-1:0]       pwdata        = '0;
	logic                    in_valid      = 1'b0;
	logic [CMD_W-1:0]        command       = '0;
	logic [IDX_W-1:0]        row_index     = '0;
	logic [IDX_W-1:0]        col_index     = '0;
	logic signed [PIX_W-1:0] pixel_in      = '0;
	logic signed [ANG_W-1:0] angle_degrees = '0;
	logic                    out_stall     = 1'b0;

	logic [DATA_W-1:0]       prdata;
	logic                    pready;
	logic                    in_stall;
	logic                    out_valid;
	logic signed [PIX_W-1:0] pixel_out;
	logic [DIM_W-1:0]        current_height;
	logic [DIM_W-1:0]        current_width;
	logic                    out_of_range;

	// predicted view state and pixel store
	logic [PIX_W-1:0] pixel_mem [0:MAX_DIM*MAX_DIM-1];
	logic [1:0]       view_turns    = 2'd0;
	logic             view_mirrored = 1'b0;
	logic [DIM_W-1:0] rows_reg      = DIM_W'(1);
	logic [DIM_W-1:0] cols_reg      = DIM_W'(1);

	read_result_t pending_reads [$];
	stim_row_t    stim_rows [$];
	int           mismatch_count = 0;
	int           send_idle_pct  = 9;
	int           recv_idle_pct  = 79;
	int           quiet_cycles   = 0;

	int phase_rows [NUM_PHASES] = '{3, 511, 0, 1, 9, 6, 8, 1, 5};
	int phase_cols [NUM_PHASES] = '{5, 1, 7, 9, 2, 4, 8, 511, 3};

	image_rotate_flip_remap u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.command        (command),
		.row_index      (row_index),
		.col_index      (col_index),
		.pixel_in       (pixel_in),
		.angle_degrees  (angle_degrees),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.pixel_out      (pixel_out),
		.current_height (current_height),
		.current_width  (current_width),
		.out_of_range   (out_of_range)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		if (mismatch_count < MAX_PRINTS) begin
			$display("MISMATCH at %0t: %s", $time, msg);
		end
		mismatch_count++;
	endtask

	function automatic int clamp_size(input logic [DIM_W-1:0] v);
		if (v == '0) begin
			return 1;
		end
		if (int'(v) > MAX_DIM) begin
			return MAX_DIM;
		end
		return int'(v);
	endfunction

	// quarter turns of an angle, rounding down (floor division), modulo 4
	function automatic logic [1:0] quarter_of(input int deg);
		int t;
		if (deg >= 0) begin
			t = (deg % 360) / 90;
		end else if (deg <= -360) begin
			t = (360 - ((-deg) % 360)) / 90;
		end else begin
			t = (deg + 360) / 90;
		end
		return t[1:0];
	endfunction

	function automatic void view_dims(output int ch, output int cw);
		if (view_turns[0]) begin
			ch = clamp_size(cols_reg);
			cw = clamp_size(rows_reg);
		end else begin
			ch = clamp_size(rows_reg);
			cw = clamp_size(cols_reg);
		end
	endfunction

	function automatic read_result_t predict_pixel_read(input logic [IDX_W-1:0] r,
			input logic [IDX_W-1:0] c);
		read_result_t res;
		int ch, cw, rr, cc, hh, ww, tmp;
		view_dims(ch, cw);
		res.h   = DIM_W'(ch);
		res.w   = DIM_W'(cw);
		res.pix = '0;
		res.oor = 1'b1;
		if (int'(r) < ch && int'(c) < cw) begin
			rr = int'(r);
			cc = int'(c);
			hh = ch;
			ww = cw;
			// undo one clockwise quarter turn per step
			for (int k = 0; k < int'(view_turns); k++) begin
				tmp = ww - 1 - cc;
				cc  = rr;
				rr  = tmp;
				tmp = hh;
				hh  = ww;
				ww  = tmp;
			end
			if (view_mirrored) begin
				cc = clamp_size(cols_reg) - 1 - cc;
			end
			res.pix = pixel_mem[rr * MAX_DIM + cc];
			res.oor = 1'b0;
		end
		return res;
	endfunction

	function automatic void model_accept(input cmd_beat_t b, input bit has_lit,
			input read_result_t lit);
		case (b.cmd)
			CMD_LOAD: pixel_mem[int'(b.row) * MAX_DIM + int'(b.col)] = b.pix;
			CMD_ROT_CW: view_turns = view_turns + quarter_of(int'(b.ang));
			CMD_ROT_CCW: view_turns = view_turns + quarter_of(-int'(b.ang));
			CMD_MIR_LR: begin
				view_turns    = 2'd0 - view_turns;
				view_mirrored = !view_mirrored;
			end
			CMD_MIR_UD: begin
				view_turns    = 2'd2 - view_turns;
				view_mirrored = !view_mirrored;
			end
			CMD_READ: pending_reads.push_back(has_lit ? lit : predict_pixel_read(b.row, b.col));
			default: ;
		endcase
	endfunction

	function automatic void add_beat(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] r,
			input logic [IDX_W-1:0] c, input logic [PIX_W-1:0] pix,
			input logic [ANG_W-1:0] ang);
		stim_row_t e;
		e = '{default: '0};
		e.beat = '{cmd, r, c, pix, ang};
		stim_rows.push_back(e);
	endfunction

	function automatic void add_lit_read(input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c,
			input logic [PIX_W-1:0] pix, input logic [DIM_W-1:0] h,
			input logic [DIM_W-1:0] w, input logic oor);
		stim_row_t e;
		e = '{default: '0};
		e.beat    = '{CMD_READ, r, c, '0, '0};
		e.has_lit = 1'b1;
		e.lit     = '{pix, h, w, oor};
		stim_rows.push_back(e);
	endfunction

	function automatic cmd_beat_t random_beat();
		cmd_beat_t b;
		int pick, ch, cw, k;
		pick  = $urandom_range(99);
		b.cmd = CMD_LOAD;
		b.row = IDX_W'($urandom_range(255));
		b.col = IDX_W'($urandom_range(255));
		b.pix = $urandom();
		b.ang = ANG_W'($urandom_range(16'hFFFF));
		if (pick < 45) begin
			b.cmd = CMD_READ;
			// most reads land inside the current view
			if ($urandom_range(3) != 0) begin
				view_dims(ch, cw);
				b.row = IDX_W'($urandom_range(ch - 1));
				b.col = IDX_W'($urandom_range(cw - 1));
			end
		end else if (pick < 69) begin
			b.cmd = (pick < 57) ? CMD_ROT_CW : CMD_ROT_CCW;
			if ($urandom_range(9) < 7) begin
				k     = int'($urandom_range(728)) - 364;
				b.ang = ANG_W'(k * 90);
			end
		end else if (pick < 75) begin
			b.cmd = CMD_MIR_LR;
		end else if (pick < 81) begin
			b.cmd = CMD_MIR_UD;
		end else if (pick >= 97) begin
			b.cmd = $urandom_range(1) ? CMD_SPARE_7 : CMD_SPARE_6;
		end
		return b;
	endfunction

	// drive one input beat, hold it until taken, then update the prediction
	task automatic issue_beat(input cmd_beat_t b, input bit has_lit, input read_result_t lit);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid      <= 1'b1;
		command       <= b.cmd;
		row_index     <= b.row;
		col_index     <= b.col;
		pixel_in      <= b.pix;
		angle_degrees <= b.ang;
		do @(posedge clk); while (in_stall !== 1'b0);
		model_accept(b, has_lit, lit);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_reads.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input reg_idx_t idx,
			input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= PADDR_W'({idx, 2'b00});
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_dims(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] cols);
		logic [DATA_W-1:0] rd;
		apb_access(1'b1, REG_NUM_ROWS, DATA_W'(rows), rd);
		apb_access(1'b1, REG_NUM_COLS, DATA_W'(cols), rd);
		rows_reg = rows;
		cols_reg = cols;
		apb_access(1'b0, REG_NUM_ROWS, '0, rd);
		if (rd[DIM_W-1:0] !== rows) begin
			report_mismatch($sformatf("num_rows read %h, wrote %h", rd, rows));
		end
		apb_access(1'b0, REG_NUM_COLS, '0, rd);
		if (rd[DIM_W-1:0] !== cols) begin
			report_mismatch($sformatf("num_cols read %h, wrote %h", rd, cols));
		end
	endtask

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin : result_check
		read_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_reads.size() == 0) begin
				report_mismatch($sformatf("result beat with none pending, pixel %h", pixel_out));
			end else begin
				want = pending_reads.pop_front();
				if (pixel_out !== want.pix) begin
					report_mismatch($sformatf("pixel_out %h, want %h", pixel_out, want.pix));
				end
				if (current_height !== want.h) begin
					report_mismatch($sformatf("current_height %0d, want %0d",
						current_height, want.h));
				end
				if (current_width !== want.w) begin
					report_mismatch($sformatf("current_width %0d, want %0d",
						current_width, want.w));
				end
				if (out_of_range !== want.oor) begin
					report_mismatch($sformatf("out_of_range %b, want %b", out_of_range, want.oor));
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		cmd_beat_t    b;
		read_result_t no_lit;
		stim_row_t    e;
		no_lit = '{default: '0};

		// reset view is 1 x 1
		add_beat(CMD_LOAD, 8'd0, 8'd0, 32'h8000_0000, 16'd0);
		add_lit_read(8'd0, 8'd0, 32'h8000_0000, 9'd1, 9'd1, 1'b0);
		add_lit_read(8'd0, 8'd1, 32'h0, 9'd1, 9'd1, 1'b1);
		add_lit_read(8'd255, 8'd255, 32'h0, 9'd1, 9'd1, 1'b1);
		// loads outside the view are still stored
		add_beat(CMD_LOAD, 8'd255, 8'd255, 32'h7FFF_FFFF, 16'd0);
		add_lit_read(8'd1, 8'd0, 32'h0, 9'd1, 9'd1, 1'b1);
		add_beat(CMD_SPARE_6, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF);
		add_beat(CMD_SPARE_7, 8'h00, 8'h00, 32'h0, 16'h0);
		e = '{default: '0};
		e.is_cfg   = 1'b1;
		e.cfg_rows = 9'd1;
		e.cfg_cols = 9'd2;
		stim_rows.push_back(e);
		add_beat(CMD_LOAD, 8'd0, 8'd0, 32'h0, 16'h7FFF);
		add_beat(CMD_LOAD, 8'd0, 8'd1, 32'hFFFF_FFFF, 16'h8000);
		add_lit_read(8'd0, 8'd1, 32'hFFFF_FFFF, 9'd1, 9'd2, 1'b0);
		add_beat(CMD_ROT_CW, 8'd0, 8'd0, 32'h0, 16'd90);
		add_beat(CMD_READ, 8'd1, 8'd0, 32'h0, 16'd0);
		add_beat(CMD_READ, 8'd0, 8'd1, 32'h0, 16'd0);
		add_beat(CMD_MIR_LR, 8'd0, 8'd0, 32'h0, 16'd0);
		add_beat(CMD_READ, 8'd0, 8'd0, 32'h0, 16'd0);
		add_beat(CMD_ROT_CCW, 8'd0, 8'd0, 32'h0, 16'h8000);
		add_beat(CMD_ROT_CW, 8'd0, 8'd0, 32'h0, 16'h7FFF);
		add_beat(CMD_ROT_CW, 8'd0, 8'd0, 32'h0, 16'd45);
		add_beat(CMD_ROT_CW, 8'd0, 8'd0, 32'h0, -16'sd360);
		add_beat(CMD_ROT_CCW, 8'd0, 8'd0, 32'h0, -16'sd450);
		add_beat(CMD_MIR_UD, 8'd0, 8'd0, 32'h0, 16'd0);
		add_beat(CMD_READ, 8'd1, 8'd0, 32'h0, 16'd0);
		add_beat(CMD_ROT_CW, 8'd0, 8'd0, 32'h0, 16'd270);
		add_beat(CMD_READ, 8'd0, 8'd0, 32'h0, 16'd0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[i]) begin
			if (stim_rows[i].is_cfg) begin
				wait_drained();
				set_dims(stim_rows[i].cfg_rows, stim_rows[i].cfg_cols);
			end else begin
				issue_beat(stim_rows[i].beat, stim_rows[i].has_lit, stim_rows[i].lit);
			end
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_drained();
			set_dims(DIM_W'(phase_rows[p]), DIM_W'(phase_cols[p]));
			if (p < 3) begin
				send_idle_pct = 9;
				recv_idle_pct = 79;
			end else if (p < 6) begin
				send_idle_pct = 79;
				recv_idle_pct = 9;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			// fill the whole original frame so every in-view read hits a loaded pixel
			for (int r = 0; r < clamp_size(rows_reg); r++) begin
				for (int c = 0; c < clamp_size(cols_reg); c++) begin
					b.cmd = CMD_LOAD;
					b.row = IDX_W'(r);
					b.col = IDX_W'(c);
					b.pix = $urandom();
					b.ang = ANG_W'($urandom_range(16'hFFFF));
					issue_beat(b, 1'b0, no_lit);
				end
			end
			repeat (RANDOM_PER_PHASE) issue_beat(random_beat(), 1'b0, no_lit);
		end

		wait_drained();
		if (mismatch_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
